/* hw/rtl/assert_macros.svh */
// Assertion macros used by the deframer parser; empty when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define WRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define WRD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WRD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/wrd_pkg.sv */
// Shared types, constants and the CRC-32 byte function of the log record deframer.
`timescale 1ns / 1ps

package wrd_pkg;

  localparam int unsigned OUT_OFFSET_W = 48;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] MAX_LEN_RESET = 32'h0400_0000;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h46, 8'h4D, 8'h57, 8'h31};
  localparam logic [7:0] CHAR_UPDATE = 8'h55;
  localparam logic [7:0] CHAR_DELETE = 8'h44;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_FINAL = 1'b1;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [2:0] {
    PH_MAGIC    = 3'd0,
    PH_BADMAGIC = 3'd1,
    PH_LEN      = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CRC      = 3'd4,
    PH_FAULT    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_CLEAN     = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_CORRUPT   = 2'd3
  } status_t;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic                    kind;
    logic                    op;
    logic [31:0]             length;
    status_t                 status;
    logic [OUT_OFFSET_W-1:0] offset;
  } res_t;

  // Reflected CRC-32 update by one byte, one polynomial step per bit.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/wrd_in_stage.sv */
// Input register of the deframer: holds one incoming transfer until the parser takes it.
`timescale 1ns / 1ps

module wrd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_file,
  input  logic          advance,
  output logic          item_valid,
  output wrd_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  wrd_pkg::item_t item_r;
  logic           load;

  // The register refills whenever it is empty or its content moves on this cycle.
  assign load     = !valid_r || advance;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r.eof  <= in_end_of_file;
      item_r.data <= in_data_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hw/rtl/wrd_parser.sv */
// Record parser: magic check, length, payload CRC, trailer check and final status.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrd_parser #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  wrd_pkg::item_t item,
  input  logic           advance,
  input  logic [31:0]    max_len,
  output logic           res_valid,
  output wrd_pkg::res_t  res
);

  wrd_pkg::phase_t        phase_r, phase_nxt;
  logic [31:0]            field_count_r, field_count_nxt;
  logic [31:0]            length_word_r, length_word_nxt;
  logic [31:0]            running_crc_r, running_crc_nxt;
  logic [31:0]            stored_crc_r, stored_crc_nxt;
  logic [7:0]             op_byte_r, op_byte_nxt;
  logic                   tab_seen_r, tab_seen_nxt;
  logic                   seen_any_r, seen_any_nxt;
  logic [OFFSET_BITS-1:0] last_good_r, last_good_nxt;

  logic                   take;
  logic [31:0]            byte_shifted;
  logic [31:0]            length_asm;
  logic [31:0]            stored_asm;
  logic [31:0]            crc_upd;
  logic [32:0]            count_inc;
  logic [OFFSET_BITS-1:0] next_good;
  logic [63:0]            good_wide;
  logic [63:0]            end_wide;

  assign take         = item_valid && advance;
  assign byte_shifted = {24'd0, item.data} << {field_count_r[1:0], 3'b000};
  assign length_asm   = length_word_r | byte_shifted;
  assign stored_asm   = stored_crc_r | byte_shifted;
  assign crc_upd      = wrd_pkg::crc32_byte(running_crc_r, item.data);
  assign count_inc    = {1'b0, field_count_r} + 33'd1;
  assign next_good    = last_good_r + OFFSET_BITS'(8) + OFFSET_BITS'(length_word_r);
  assign good_wide    = 64'(last_good_r);
  assign end_wide     = 64'(next_good);

  always_comb begin
    phase_nxt       = phase_r;
    field_count_nxt = field_count_r;
    length_word_nxt = length_word_r;
    running_crc_nxt = running_crc_r;
    stored_crc_nxt  = stored_crc_r;
    op_byte_nxt     = op_byte_r;
    tab_seen_nxt    = tab_seen_r;
    seen_any_nxt    = seen_any_r;
    last_good_nxt   = last_good_r;
    res_valid       = 1'b0;
    res             = '0;

    if (take && item.eof) begin
      res_valid  = 1'b1;
      res.kind   = wrd_pkg::KIND_FINAL;
      res.offset = good_wide[wrd_pkg::OUT_OFFSET_W-1:0];
      case (phase_r)
        wrd_pkg::PH_MAGIC: begin
          res.status = seen_any_r ? wrd_pkg::ST_BAD_MAGIC : wrd_pkg::ST_EMPTY;
          res.offset = '0;
        end
        wrd_pkg::PH_BADMAGIC: begin
          res.status = wrd_pkg::ST_BAD_MAGIC;
          res.offset = '0;
        end
        wrd_pkg::PH_LEN: begin
          res.status = (field_count_r == 32'd0) ? wrd_pkg::ST_CLEAN : wrd_pkg::ST_CORRUPT;
        end
        default: begin
          res.status = wrd_pkg::ST_CORRUPT;
        end
      endcase
      // The final report rearms the parser for the next file.
      phase_nxt       = wrd_pkg::PH_MAGIC;
      field_count_nxt = '0;
      length_word_nxt = '0;
      running_crc_nxt = wrd_pkg::CRC_INIT;
      stored_crc_nxt  = '0;
      op_byte_nxt     = '0;
      tab_seen_nxt    = 1'b0;
      seen_any_nxt    = 1'b0;
      last_good_nxt   = OFFSET_BITS'(4);
    end else if (take) begin
      seen_any_nxt = 1'b1;
      case (phase_r)
        wrd_pkg::PH_MAGIC: begin
          if (item.data != wrd_pkg::MAGIC_BYTES[field_count_r[1:0]]) begin
            phase_nxt = wrd_pkg::PH_BADMAGIC;
          end else if (field_count_r >= 32'd3) begin
            phase_nxt       = wrd_pkg::PH_LEN;
            field_count_nxt = '0;
            length_word_nxt = '0;
            running_crc_nxt = wrd_pkg::CRC_INIT;
            stored_crc_nxt  = '0;
            op_byte_nxt     = '0;
            tab_seen_nxt    = 1'b0;
          end else begin
            field_count_nxt = count_inc[31:0];
          end
        end
        wrd_pkg::PH_LEN: begin
          length_word_nxt = length_asm;
          if (field_count_r < 32'd3) begin
            field_count_nxt = count_inc[31:0];
          end else begin
            field_count_nxt = '0;
            if (length_asm > max_len) begin
              phase_nxt = wrd_pkg::PH_FAULT;
            end else if (length_asm == 32'd0) begin
              phase_nxt = wrd_pkg::PH_CRC;
            end else begin
              phase_nxt = wrd_pkg::PH_PAYLOAD;
            end
          end
        end
        wrd_pkg::PH_PAYLOAD: begin
          running_crc_nxt = crc_upd;
          if (field_count_r == 32'd0) begin
            op_byte_nxt = item.data;
          end else if (field_count_r == 32'd1) begin
            tab_seen_nxt = (item.data == wrd_pkg::CHAR_TAB);
          end
          field_count_nxt = count_inc[31:0];
          if (count_inc >= {1'b0, length_word_r}) begin
            field_count_nxt = '0;
            phase_nxt       = wrd_pkg::PH_CRC;
          end
        end
        wrd_pkg::PH_CRC: begin
          stored_crc_nxt = stored_asm;
          if (field_count_r < 32'd3) begin
            field_count_nxt = count_inc[31:0];
          end else if (stored_asm != ~running_crc_r || !tab_seen_r ||
                       (op_byte_r != wrd_pkg::CHAR_UPDATE &&
                        op_byte_r != wrd_pkg::CHAR_DELETE)) begin
            phase_nxt = wrd_pkg::PH_FAULT;
          end else begin
            res_valid  = 1'b1;
            res.kind   = wrd_pkg::KIND_RECORD;
            res.op     = (op_byte_r == wrd_pkg::CHAR_DELETE) ?
                         wrd_pkg::OP_DELETE : wrd_pkg::OP_UPDATE;
            res.length = length_word_r;
            res.status = wrd_pkg::ST_EMPTY;
            res.offset = end_wide[wrd_pkg::OUT_OFFSET_W-1:0];
            last_good_nxt   = next_good;
            phase_nxt       = wrd_pkg::PH_LEN;
            field_count_nxt = '0;
            length_word_nxt = '0;
            running_crc_nxt = wrd_pkg::CRC_INIT;
            stored_crc_nxt  = '0;
            op_byte_nxt     = '0;
            tab_seen_nxt    = 1'b0;
          end
        end
        default: begin
          // Bad magic, fault and unused codes ignore every byte.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= wrd_pkg::PH_MAGIC;
      field_count_r <= '0;
      length_word_r <= '0;
      running_crc_r <= wrd_pkg::CRC_INIT;
      stored_crc_r  <= '0;
      op_byte_r     <= '0;
      tab_seen_r    <= 1'b0;
      seen_any_r    <= 1'b0;
      last_good_r   <= OFFSET_BITS'(4);
    end else begin
      phase_r       <= phase_nxt;
      field_count_r <= field_count_nxt;
      length_word_r <= length_word_nxt;
      running_crc_r <= running_crc_nxt;
      stored_crc_r  <= stored_crc_nxt;
      op_byte_r     <= op_byte_nxt;
      tab_seen_r    <= tab_seen_nxt;
      seen_any_r    <= seen_any_nxt;
      last_good_r   <= last_good_nxt;
    end
  end

  `WRD_ASSERT_NXT(a_eof_rearms, clk, rst_n, take && item.eof, phase_r == wrd_pkg::PH_MAGIC)
  `WRD_ASSERT_NXT(a_fault_sticky, clk, rst_n, phase_r == wrd_pkg::PH_FAULT && !(take && item.eof), phase_r == wrd_pkg::PH_FAULT)
  `WRD_ASSERT_IMP(a_record_from_crc, clk, rst_n, res_valid && res.kind == wrd_pkg::KIND_RECORD, phase_r == wrd_pkg::PH_CRC && field_count_r == 32'd3)
  `WRD_ASSERT_IMP(a_len_count, clk, rst_n, phase_r == wrd_pkg::PH_LEN || phase_r == wrd_pkg::PH_MAGIC, field_count_r < 32'd4)

endmodule

/* hw/rtl/wrd_out_stage.sv */
// Result register of the deframer: holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module wrd_out_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 res_valid,
  input  wrd_pkg::res_t                        res,
  output logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_kind,
  output logic                                 out_record_op,
  output logic [31:0]                          out_payload_length,
  output logic [1:0]                           out_final_status,
  output logic [wrd_pkg::OUT_OFFSET_W-1:0]     out_good_offset
);

  logic          valid_r;
  logic          valid_nxt;
  wrd_pkg::res_t res_r;

  // The parser may step whenever this register is free or is emptied in this cycle.
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = res_r.kind;
  assign out_record_op      = res_r.op;
  assign out_payload_length = res_r.length;
  assign out_final_status   = res_r.status;
  assign out_good_offset    = res_r.offset;

endmodule

/* hw/rtl/wal_record_deframer_crc32.sv */
// Top level of the write-ahead-log record deframer with CRC-32 check.
`timescale 1ns / 1ps

// The block takes a log file one byte per transfer, followed by one transfer with
// in_end_of_file set. The file must open with the magic "FMW1"; records follow, each a
// little-endian 32-bit length, the payload and a little-endian CRC-32 of the payload
// (reflected, init all ones, final invert). A record whose length is at most the
// configured limit, whose CRC matches, whose first byte is 'U' or 'D' and whose second
// byte is a tab produces one record transfer with its op, length and the file offset just
// after it. The first fault freezes parsing until end of file. The end-of-file transfer
// always produces one final status transfer (empty, clean, bad magic with offset zero, or
// corrupt tail with the last good offset) and rearms the block for a new file; the limit
// register keeps its value. The block accepts one byte per clock cycle when the result
// side is not stalling; a result is offered once its byte has passed the input register,
// where the parser works on it, and the result register has loaded. That rate is set by
// the parser, which applies the CRC-32 byte update and all field checks combinationally.
// No clearing pass is needed after reset. The configuration channel is always ready, and
// the limit must be written only while no transfer is in flight.

module wal_record_deframer_crc32 #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_file,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic                             out_record_op,
  output logic [31:0]                      out_payload_length,
  output logic [1:0]                       out_final_status,
  output logic [wrd_pkg::OUT_OFFSET_W-1:0] out_good_offset
);

  logic [31:0]    max_len_r;
  logic [31:0]    max_len_nxt;
  logic           advance;
  logic           item_valid;
  wrd_pkg::item_t item;
  logic           res_valid;
  wrd_pkg::res_t  res;

  // The limit register takes a write transfer in any cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_valid && cfg_ready) begin
      max_len_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wrd_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // Input register: stalls upstream only while it is full and cannot move on.
  wrd_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .advance        (advance),
    .item_valid     (item_valid),
    .item           (item)
  );

  // Parser: consumes the registered byte and computes the next parse state combinationally.
  wrd_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .max_len    (max_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: decides when the pipeline may step.
  wrd_out_stage u_out_stage (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res_valid),
    .res                (res),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_record_op      (out_record_op),
    .out_payload_length (out_payload_length),
    .out_final_status   (out_final_status),
    .out_good_offset    (out_good_offset)
  );

endmodule
